// ----- design/fvn_pkg.sv -----
// Shared types, constants and helper functions for the fractal value noise sampler.
// No dependencies; the front end, back end and top level import this package.
`default_nettype none

package fvn_pkg;

  localparam int TableBits = 8;
  localparam int TableSize = 1 << TableBits;
  localparam int FracBits  = 16;
  localparam int PosW      = TableBits + FracBits;
  localparam int OutW      = 16;
  localparam int MaxOct    = TableBits + 1;
  localparam int CornerN   = 8;
  localparam int QDepth    = 4;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int WeightW   = FracBits + 1;
  localparam int AmpW      = 17;
  localparam int AccW      = 21;
  localparam int SumW      = 37;
  localparam int ProdW     = 33;
  localparam int QuoW      = 16;
  localparam int CfgDataW  = 16;

  localparam logic [WeightW-1:0] OneF = WeightW'(1) << FracBits;
  localparam logic [AmpW-1:0]    AmpOne = AmpW'(65536);

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [0:0] CFG_OCTAVE_COUNT = 1'b0;
  localparam logic [0:0] CFG_PERSISTENCE  = 1'b1;

  // one queued command after classification
  typedef struct packed {
    logic                               cmd;
    logic [TableBits-1:0]               idx;
    logic [TableBits-1:0]               val;
    logic [2:0][TableBits-1:0]          ip;
    logic [2:0][FracBits-1:0]           fr;
  } fvn_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADDR, ST_YRD, ST_ZRD,
    ST_L1M, ST_L1A, ST_L2M, ST_L2A, ST_L3M, ST_L3A,
    ST_ACC, ST_SUM, ST_DIV, ST_DONE
  } fvn_state_t;

  // finish a lerp from the registered base, direction and product
  function automatic logic [FracBits-1:0] lerp_add(input logic [FracBits-1:0] a,
                                                   input logic ge,
                                                   input logic [ProdW-1:0] p);
    logic [FracBits-1:0] step;
    step = FracBits'(p >> FracBits);
    return ge ? a + step : a - step;
  endfunction

endpackage

`default_nettype wire

// ----- design/fvn_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module fvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/fvn_front.sv -----
// Front end: accepts commands, splits positions into lattice and fraction parts,
// and holds them in a short queue for the back end. Depends on fvn_pkg.
`default_nettype none

module fvn_front import fvn_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic            command,
  input  wire logic [7:0]      entry_index,
  input  wire logic [7:0]      entry_value,
  input  wire logic [PosW-1:0] pos_x,
  input  wire logic [PosW-1:0] pos_y,
  input  wire logic [PosW-1:0] pos_z,
  output logic                 q_valid,
  output fvn_item_t            q_head,
  input  wire logic            q_pop
);

  fvn_item_t        slots [QDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QPtrW:0]   count;
  fvn_item_t        cls;
  logic             do_push;
  logic             do_pop;

  // classify: integer part wraps at the table size
  always_comb begin
    cls.cmd   = command;
    cls.idx   = entry_index;
    cls.val   = entry_value;
    cls.ip[0] = pos_x[PosW-1:FracBits];
    cls.ip[1] = pos_y[PosW-1:FracBits];
    cls.ip[2] = pos_z[PosW-1:FracBits];
    cls.fr[0] = pos_x[FracBits-1:0];
    cls.fr[1] = pos_y[FracBits-1:0];
    cls.fr[2] = pos_z[FracBits-1:0];
  end

  assign full    = (count == (QPtrW+1)'(QDepth));
  assign q_valid = (count != '0);
  assign q_head  = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // store transfers
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= cls;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- design/fvn_back.sv -----
// Back end: octave sequencer with eight replicated hash tables, fade, trilinear
// blend, weighted sum and a bit-serial divider. Depends on fvn_pkg and fvn_ram.
`default_nettype none

module fvn_back import fvn_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire fvn_item_t           q_head,
  output logic                     q_pop,
  input  wire logic [3:0]          octave_count,
  input  wire logic [15:0]         persistence,
  output logic                     res_valid,
  output logic [OutW-1:0]          res_data,
  input  wire logic                res_ready
);

  fvn_state_t state, state_next;

  logic [2:0][TableBits-1:0] ip;
  logic [2:0][FracBits-1:0]  fr;
  logic [3:0]                oi;
  logic [3:0]                n_oct;
  logic [3:0]                shift;
  logic [TableBits-1:0]      low_mask;
  logic [TableBits:0]        span;
  logic [2:0][TableBits-1:0] lo;
  logic [2:0][TableBits-1:0] hi;
  logic [2:0][FracBits-1:0]  t_c;

  logic [2:0][FracBits-1:0]  t_r;
  logic [2:0][FracBits-1:0]  t2_r;
  logic [2:0][FracBits-1:0]  t3_r;
  logic [2:0][19:0]          q_r;
  logic [2:0][WeightW-1:0]   w_r;

  logic                      ram_we;
  logic [TableBits-1:0]      raddr [CornerN];
  logic [TableBits-1:0]      rdata [CornerN];

  logic [FracBits-1:0]       src [CornerN];
  logic [WeightW-1:0]        w_sel;
  logic [FracBits-1:0]       la [4];
  logic                      lge [4];
  logic [ProdW-1:0]          lp [4];
  logic [FracBits-1:0]       lv [4];

  logic [AmpW-1:0]           amp;
  logic [AccW-1:0]           acc;
  logic [SumW-1:0]           sum;
  logic [SumW-1:0]           sum_new;
  logic [ProdW-1:0]          pa_r;
  logic [SumW-1:0]           rem;
  logic [SumW-1:0]           dvs;
  logic [QuoW-1:0]           quo;
  logic [3:0]                dcnt;
  logic                      last_oct;

  // effective octave count: zero means one, spacing stays at least one
  always_comb begin
    if (octave_count == 4'd0) begin
      n_oct = 4'd1;
    end else if (octave_count > 4'(MaxOct)) begin
      n_oct = 4'(MaxOct);
    end else begin
      n_oct = octave_count;
    end
  end

  assign last_oct = (5'(oi) + 5'd1 >= 5'(n_oct));

  // lattice cell of the current octave
  assign shift    = 4'(TableBits) - oi;
  assign span     = (TableBits+1)'(1) << shift;
  assign low_mask = TableBits'(span - 1'b1);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo[k]  = ip[k] & ~low_mask;
      hi[k]  = TableBits'({1'b0, lo[k]} + span);
      t_c[k] = FracBits'({ip[k] & low_mask, fr[k]} >> shift);
    end
  end

  // chained lookup addresses, one table copy per corner
  always_comb begin
    for (int c = 0; c < CornerN; c++) begin
      case (state)
        ST_YRD:  raddr[c] = rdata[c] + (c[1] ? hi[1] : lo[1]);
        ST_ZRD:  raddr[c] = rdata[c] + (c[2] ? hi[2] : lo[2]);
        default: raddr[c] = c[0] ? hi[0] : lo[0];
      endcase
    end
  end

  assign ram_we = (state == ST_IDLE) && q_valid && (q_head.cmd == CMD_WRITE);

  for (genvar g = 0; g < CornerN; g++) begin : g_tab
    fvn_ram #(.WIDTH(TableBits), .DEPTH(TableSize)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (q_head.idx),
      .wdata (q_head.val),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  // lerp operand selection per blend level
  always_comb begin
    for (int i = 0; i < CornerN; i++) begin
      if (state == ST_L1M) begin
        src[i] = {rdata[i], (FracBits-TableBits)'(0)};
      end else if (i < 4) begin
        src[i] = lv[i];
      end else begin
        src[i] = '0;
      end
    end
    case (state)
      ST_L1M:  w_sel = w_r[0];
      ST_L2M:  w_sel = w_r[1];
      default: w_sel = w_r[2];
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshakes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.cmd == CMD_SAMPLE) state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_YRD;
      ST_YRD:  state_next = ST_ZRD;
      ST_ZRD:  state_next = ST_L1M;
      ST_L1M:  state_next = ST_L1A;
      ST_L1A:  state_next = ST_L2M;
      ST_L2M:  state_next = ST_L2A;
      ST_L2A:  state_next = ST_L3M;
      ST_L3M:  state_next = ST_L3A;
      ST_L3A:  state_next = ST_ACC;
      ST_ACC:  state_next = ST_SUM;
      ST_SUM:  state_next = last_oct ? ST_DIV : ST_ADDR;
      ST_DIV: begin
        if (dcnt == 4'(QuoW - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign sum_new  = sum + SumW'(pa_r);
  assign res_data = quo;

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ip  <= q_head.ip;
        fr  <= q_head.fr;
        oi  <= '0;
        amp <= AmpOne;
        acc <= '0;
        sum <= '0;
      end
      ST_ADDR: begin
        for (int k = 0; k < 3; k++) begin
          t_r[k]  <= t_c[k];
          t2_r[k] <= FracBits'((32'(t_c[k]) * 32'(t_c[k])) >> FracBits);
        end
      end
      ST_YRD: begin
        for (int k = 0; k < 3; k++) begin
          t3_r[k] <= FracBits'((32'(t2_r[k]) * 32'(t_r[k])) >> FracBits);
          q_r[k]  <= 20'(21'(t2_r[k]) * 21'd6 + 21'(OneF) * 21'd10
                     - 21'(t_r[k]) * 21'd15);
        end
      end
      ST_ZRD: begin
        for (int k = 0; k < 3; k++) begin
          logic [35:0] r;
          r = (36'(t3_r[k]) * 36'(q_r[k])) >> FracBits;
          w_r[k] <= (r > 36'(OneF)) ? OneF : WeightW'(r);
        end
      end
      ST_L1M, ST_L2M, ST_L3M: begin
        for (int j = 0; j < 4; j++) begin
          logic [FracBits-1:0] d;
          d = (src[2*j+1] >= src[2*j]) ? src[2*j+1] - src[2*j] : src[2*j] - src[2*j+1];
          la[j]  <= src[2*j];
          lge[j] <= (src[2*j+1] >= src[2*j]);
          lp[j]  <= ProdW'(d) * ProdW'(w_sel);
        end
      end
      ST_L1A, ST_L2A, ST_L3A: begin
        for (int j = 0; j < 4; j++) begin
          lv[j] <= lerp_add(la[j], lge[j], lp[j]);
        end
      end
      ST_ACC: begin
        pa_r <= ProdW'(amp) * ProdW'(lv[0]);
        amp  <= AmpW'((34'(amp) * 34'(persistence)) >> 16);
        acc  <= acc + AccW'(amp);
      end
      ST_SUM: begin
        sum  <= sum_new;
        oi   <= oi + 1'b1;
        rem  <= sum_new;
        dvs  <= SumW'(acc) << (QuoW - 1);
        dcnt <= '0;
      end
      ST_DIV: begin
        // one quotient bit a cycle
        if (rem >= dvs) begin
          rem <= rem - dvs;
          quo <= {quo[QuoW-2:0], 1'b1};
        end else begin
          quo <= {quo[QuoW-2:0], 1'b0};
        end
        dvs  <= dvs >> 1;
        dcnt <= dcnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/fractal_value_noise_sampler.sv -----
// Top level of the fractal value noise sampler: configuration registers, front
// and back ends, and the result queue. Depends on fvn_pkg, fvn_front, fvn_back.
//
// A write command loads one hash table entry as the back end pops it; it never
// produces a result. In a sample, each octave runs three chained table reads
// on eight table copies, the fade and a three-level blend through one shared
// interpolation datapath, then the weighted sum; a bit-serial divider forming
// a 16-bit quotient normalizes the total. Samples are processed one at a time
// in the back end, while a four-entry command queue keeps accepting and a
// two-entry result queue holds finished values. Table entries are undefined
// until written.
`default_nettype none

module fractal_value_noise_sampler import fvn_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                command,
  input  wire logic [7:0]          entry_index,
  input  wire logic [7:0]          entry_value,
  input  wire logic [PosW-1:0]     pos_x,
  input  wire logic [PosW-1:0]     pos_y,
  input  wire logic [PosW-1:0]     pos_z,
  output logic                     empty,
  input  wire logic                pop,
  output logic [OutW-1:0]          noise_value,
  input  wire logic                cfg_write,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic [3:0]      octave_count;
  logic [15:0]     persistence;
  logic            q_valid;
  fvn_item_t       q_head;
  logic            q_pop;
  logic            res_valid;
  logic [OutW-1:0] res_data;
  logic            res_ready;
  logic [OutW-1:0] obuf [2];
  logic            owp;
  logic            orp;
  logic [1:0]      ocnt;
  logic            opush;
  logic            opop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= 4'd4;
      persistence  <= 16'd32768;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        CFG_PERSISTENCE:  persistence  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  fvn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  fvn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .octave_count (octave_count),
    .persistence  (persistence),
    .res_valid    (res_valid),
    .res_data     (res_data),
    .res_ready    (res_ready)
  );

  // result queue
  assign res_ready   = (ocnt != 2'd2);
  assign opush       = res_valid && res_ready;
  assign opop        = pop && !empty;
  assign empty       = (ocnt == 2'd0);
  assign noise_value = obuf[orp];

  always_ff @(posedge clk) begin
    if (opush) begin
      obuf[owp] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (opush) owp <= ~owp;
      if (opop)  orp <= ~orp;
      ocnt <= ocnt + 2'(opush) - 2'(opop);
    end
  end

endmodule

`default_nettype wire

// ----- design/fvn_checker.sv -----
// Port-level checker for the fractal value noise sampler, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module fvn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [15:0] noise_value
);

  // queues come out of reset drained
  a_reset_drained: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not drained after reset");

  // no result can appear too early after reset
  a_min_latency: assert property (@(posedge clk) rst |-> ##1 empty ##1 empty)
    else $error("result appeared too early after reset");

  // a waiting result stays until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result dropped without transfer");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(noise_value))
    else $error("result changed while waiting");

endmodule

bind fractal_value_noise_sampler fvn_checker u_fvn_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .noise_value (noise_value)
);

`default_nettype wire

// ----- test/tb_fractal_value_noise_sampler.sv -----
// Testbench for fractal_value_noise_sampler: loads the lattice table, samples noise
// under several octave and persistence settings, and checks each value against a
// local predictor. Depends on fvn_pkg and the sampler RTL.
`timescale 1ns / 100ps

module tb_fractal_value_noise_sampler;
  import fvn_pkg::*;

  localparam int RunLimit = 1000000;
  localparam int DrainCycles = 160;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic command = CMD_WRITE;
  logic [7:0] entry_index = '0;
  logic [7:0] entry_value = '0;
  logic [PosW-1:0] pos_x = '0;
  logic [PosW-1:0] pos_y = '0;
  logic [PosW-1:0] pos_z = '0;
  logic empty;
  logic pop = 1'b0;
  logic [OutW-1:0] noise_value;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = CFG_OCTAVE_COUNT;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predictor state
  logic [7:0] lattice [TableSize];
  logic [3:0] octaves_cfg;
  logic [15:0] persist_cfg;
  logic [OutW-1:0] noise_expected [$];

  int errors = 0;
  int cycles = 0;
  int samples_sent = 0;
  int writes_sent = 0;
  int values_checked = 0;
  bit idle_on = 1'b1;

  fractal_value_noise_sampler dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .entry_index(entry_index), .entry_value(entry_value),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .empty(empty), .pop(pop), .noise_value(noise_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned corner_level(longint unsigned x, longint unsigned y,
                                                   longint unsigned z);
    longint unsigned hx, hy, hz;
    hx = 64'(lattice[x % TableSize]);
    hy = 64'(lattice[(hx + y) % TableSize]);
    hz = 64'(lattice[(hy + z) % TableSize]);
    return (hz << FracBits) / TableSize;
  endfunction

  function automatic longint unsigned quintic_fade(longint unsigned t);
    longint unsigned t2, t3, q, r;
    t2 = (t * t) >> FracBits;
    t3 = (t2 * t) >> FracBits;
    q = 6 * t2 + 10 * (64'd1 << FracBits) - 15 * t;
    r = (t3 * q) >> FracBits;
    return (r > (64'd1 << FracBits)) ? (64'd1 << FracBits) : r;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned t);
    if (b >= a) return a + (((b - a) * t) >> FracBits);
    return a - (((a - b) * t) >> FracBits);
  endfunction

  function automatic logic [OutW-1:0] predict_noise(logic [PosW-1:0] px, logic [PosW-1:0] py,
                                                    logic [PosW-1:0] pz);
    longint unsigned lat [3];
    longint unsigned frac [3];
    longint unsigned lo [3];
    longint unsigned hi [3];
    longint unsigned w [3];
    longint unsigned c [8];
    longint unsigned spacing, amp, acc, total, near_v, far_v, octave_v, local_pos;
    int n;
    lat[0] = 64'(px[PosW-1:FracBits]); frac[0] = 64'(px[FracBits-1:0]);
    lat[1] = 64'(py[PosW-1:FracBits]); frac[1] = 64'(py[FracBits-1:0]);
    lat[2] = 64'(pz[PosW-1:FracBits]); frac[2] = 64'(pz[FracBits-1:0]);
    n = (octaves_cfg == 0) ? 1 : int'(octaves_cfg);
    spacing = TableSize;
    amp = 65536;
    acc = 0;
    total = 0;
    for (int i = 0; i < n && spacing != 0; i++) begin
      for (int k = 0; k < 3; k++) begin
        lo[k] = (lat[k] / spacing) * spacing;
        hi[k] = lo[k] + spacing;
        local_pos = ((lat[k] - lo[k]) << FracBits) + frac[k];
        w[k] = quintic_fade(local_pos / spacing);
      end
      // corner j: bit 0 picks high x, bit 1 high y, bit 2 high z
      for (int j = 0; j < 8; j++)
        c[j] = corner_level(j[0] ? hi[0] : lo[0], j[1] ? hi[1] : lo[1],
                            j[2] ? hi[2] : lo[2]);
      near_v = blend(blend(c[0], c[1], w[0]), blend(c[2], c[3], w[0]), w[1]);
      far_v = blend(blend(c[4], c[5], w[0]), blend(c[6], c[7], w[0]), w[1]);
      octave_v = blend(near_v, far_v, w[2]);
      total += amp * octave_v;
      acc += amp;
      amp = (amp * 64'(persist_cfg)) >> 16;
      spacing >>= 1;
    end
    return OutW'(total / acc);
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(input string what);
    errors++;
    $display("ERROR @%0d: %s", cycles, what);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // compare each transferred result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (noise_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected noise_value %0h", noise_value));
      end else begin
        if (noise_value !== noise_expected[0])
          report_mismatch($sformatf("noise_value %0h, expected %0h",
                                    noise_value, noise_expected[0]));
        void'(noise_expected.pop_front());
        values_checked++;
      end
    end
  end

  // result side: stall in random bursts
  always @(negedge clk) begin
    int hold;
    if (hold > 0) begin
      hold--;
      pop = 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      hold = $urandom_range(1, 18) - 1;
      pop = 1'b0;
    end else begin
      pop = 1'b1;
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_item(input logic cmd, input logic [7:0] idx, input logic [7:0] val,
                           input logic [PosW-1:0] px, input logic [PosW-1:0] py,
                           input logic [PosW-1:0] pz);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    push = 1'b1;
    command = cmd;
    entry_index = idx;
    entry_value = val;
    pos_x = px;
    pos_y = py;
    pos_z = pz;
    do @(posedge clk); while (full);
    // transfer happened at this edge
    if (cmd == CMD_SAMPLE) begin
      noise_expected.push_back(predict_noise(px, py, pz));
      samples_sent++;
    end else begin
      lattice[idx] = val;
      writes_sent++;
    end
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic send_sample(input logic [PosW-1:0] px, input logic [PosW-1:0] py,
                             input logic [PosW-1:0] pz);
    send_item(CMD_SAMPLE, 8'($urandom), 8'($urandom), px, py, pz);
  endtask

  task automatic wait_idle();
    while (noise_expected.size() != 0) @(negedge clk);
    // a table write may still be in flight
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_config(input logic [0:0] idx, input logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == CFG_OCTAVE_COUNT) octaves_cfg = data[3:0];
    else persist_cfg = data;
  endtask

  function automatic logic [PosW-1:0] rand_pos();
    return PosW'($urandom);
  endfunction

  // fill every entry so no sample reads an unwritten one
  task automatic test_table_load();
    for (int i = 0; i < TableSize; i++)
      send_item(CMD_WRITE, 8'(i), (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'($urandom),
                rand_pos(), rand_pos(), rand_pos());
  endtask

  // field extremes and both commands under reset configuration
  task automatic test_directed();
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample(24'hFF_0000, 24'h00_FFFF, 24'h80_8000);
    send_sample(24'h00_0001, 24'hFF_FFFE, 24'h7F_FFFF);
    send_item(CMD_WRITE, 8'd255, 8'd255, '1, '1, '1);
    send_item(CMD_WRITE, 8'd0, 8'd0, '0, '0, '0);
    send_sample(24'h01_0000, 24'h02_0000, 24'h03_0000);
    send_sample(24'hAA_AAAA, 24'h55_5555, 24'hF0_0F0F);
  endtask

  // octave count zero, one, the deepest, and beyond; persistence extremes
  task automatic test_config_extremes();
    logic [CfgDataW-1:0] oct_set [4] = '{16'd0, 16'd1, 16'd9, 16'd15};
    logic [15:0] per_set [2] = '{16'd0, 16'hFFFF};
    foreach (oct_set[i]) begin
      write_config(CFG_OCTAVE_COUNT, oct_set[i]);
      foreach (per_set[j]) begin
        write_config(CFG_PERSISTENCE, per_set[j]);
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        repeat (3) send_sample(rand_pos(), rand_pos(), rand_pos());
      end
    end
  endtask

  // random mix of table writes and samples over random settings
  task automatic test_random(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      write_config(CFG_OCTAVE_COUNT,
                   CfgDataW'($urandom_range(0, 4) == 0 ? $urandom_range(0, 15)
                                                       : $urandom_range(1, 4)));
      write_config(CFG_PERSISTENCE, CfgDataW'($urandom));
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 4) == 0)
          send_item(CMD_WRITE, 8'($urandom), 8'($urandom), rand_pos(), rand_pos(),
                    rand_pos());
        else
          send_sample(rand_pos(), rand_pos(), rand_pos());
        // hold off now and then until the result queue drains
        if (i == per_phase / 2 && p % 2 == 0)
          while (noise_expected.size() != 0) @(negedge clk);
      end
    end
  endtask

  initial begin
    octaves_cfg = 4'd4;
    persist_cfg = 16'd32768;
    repeat (2) @(negedge clk);
    rst = 1'b0;
    test_table_load();
    test_directed();
    test_config_extremes();
    test_random(10, 45);
    idle_on = 1'b0;
    test_random(2, 40);
    wait_idle();
    $display("Sent %0d samples and %0d table writes; checked %0d noise values.",
             samples_sent, writes_sent, values_checked);
    $display("Covered octave counts 0..15, persistence 0 and full scale, all field extremes.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
